// File: sv/scba_pkg.sv
package scba_pkg;

	// Default geometry of the allocator
	localparam int BLOCKS_PER_CLASS = 256;
	localparam int NUM_CLASSES      = 8;
	localparam int MIN_BLOCK_BYTES  = 16;

	// Result status codes
	localparam logic [2:0] ST_GRANTED   = 3'd0;
	localparam logic [2:0] ST_EXHAUSTED = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE = 3'd2;
	localparam logic [2:0] ST_ZERO      = 3'd3;
	localparam logic [2:0] ST_FREED     = 3'd4;
	localparam logic [2:0] ST_FREE_ERR  = 3'd5;

	// Request operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Request beat
	typedef struct packed {
		logic        operation;
		logic [11:0] request_size;
		logic [2:0]  free_class;
		logic [7:0]  free_block;
	} req_t;

	// Response beat
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] grant_class;
		logic [7:0] grant_block;
		logic [8:0] class_in_use;
	} rsp_t;

endpackage

// File: sv/size_class_block_allocator.sv
// Size-class block allocator: per-class LIFO free stacks of block indices.
// Request channel (req_valid / req_stall / req): one beat is either an
// allocate of request_size bytes or a free of (free_class, free_block).
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// request, in request order, with status, granted class and block, and the
// in-use count of the affected class after the operation.
// Throughput: one request per cycle while req_stall is low. Class choice, count
// update and the stack memory access all happen at the edge that accepts the
// request; the stack memory's registered read and the read stage register feed
// the response register, which drives rsp.
// Reset clears all in-use counts and the per-class peak marks. No clearing
// pass runs over the stack memory: a stack position never written since
// reset is detected from the peak mark and reads as its own index, so the
// block accepts requests as soon as reset is released.
// When the receiver stalls, the response register holds; one more request
// is absorbed in the read stage, then req_stall rises until rsp is taken.
module size_class_block_allocator #(
	parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS,
	parameter int NUM_CLASSES      = scba_pkg::NUM_CLASSES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  scba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scba_pkg::rsp_t rsp
);

	localparam int CW  = $clog2(BLOCKS_PER_CLASS + 1);
	localparam int BW  = $clog2(BLOCKS_PER_CLASS);
	localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int AW  = $clog2(NUM_CLASSES * BLOCKS_PER_CLASS);

	logic [CW-1:0] count_q [NUM_CLASSES];
	logic [CW-1:0] peak_q  [NUM_CLASSES];

	logic                   s1_valid_q;
	logic [2:0]             st_s1;
	logic [2:0]             cls_s1;
	logic [CW-1:0]          cnt_s1;
	logic                   mem_s1;
	logic [BW-1:0]          rst_s1;
	logic                   rsp_valid_q;
	scba_pkg::rsp_t         rsp_q;

	logic                   rsp_adv;
	logic                   s1_adv;
	logic                   in_acc;

	logic [NUM_CLASSES-1:0] fit;
	logic [NUM_CLASSES-1:0] avail;
	logic [CLW-1:0]         first_cls;
	logic [CLW-1:0]         grant_cls;
	logic [CLW-1:0]         fcls_idx;
	logic [CW-1:0]          top_g;
	logic [CW-1:0]          top_f;
	logic                   use_mem;

	logic                   do_grant;
	logic                   do_free;
	logic [2:0]             st_d;
	logic [2:0]             cls_d;
	logic [CW-1:0]          cnt_d;

	logic [AW-1:0]          raddr;
	logic [AW-1:0]          waddr;
	logic [BW-1:0]          rdata;

	// Handshake: advance the response register, then the read stage
	assign rsp_adv   = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = s1_valid_q && rsp_adv;
	assign req_stall = s1_valid_q && !rsp_adv;
	assign in_acc    = req_valid && !req_stall;

	// Find fitting classes and pick the smallest fitting and smallest free one
	always_comb begin
		fit       = '0;
		avail     = '0;
		first_cls = '0;
		grant_cls = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			fit[c]   = 32'(req.request_size) <= (32'(scba_pkg::MIN_BLOCK_BYTES) << c);
			avail[c] = fit[c] && (count_q[c] < CW'(BLOCKS_PER_CLASS));
		end
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (fit[c]) begin
				first_cls = CLW'(c);
			end
			if (avail[c]) begin
				grant_cls = CLW'(c);
			end
		end
	end

	assign fcls_idx = CLW'(req.free_class);
	assign top_g    = count_q[grant_cls];
	assign top_f    = count_q[fcls_idx] - CW'(1);
	// A stack slot below the peak was pushed by a free; one at or above it reads as its own index
	assign use_mem  = top_g < peak_q[grant_cls];

	// Decode the request outcome
	always_comb begin
		do_grant = 1'b0;
		do_free  = 1'b0;
		st_d     = scba_pkg::ST_ZERO;
		cls_d    = '0;
		cnt_d    = '0;
		if (req.operation == scba_pkg::OP_ALLOC) begin
			if (req.request_size == '0) begin
				st_d = scba_pkg::ST_ZERO;
			end else if (!fit[NUM_CLASSES-1]) begin
				st_d = scba_pkg::ST_TOO_LARGE;
			end else if (|avail) begin
				do_grant = 1'b1;
				st_d     = scba_pkg::ST_GRANTED;
				cls_d    = 3'(grant_cls);
				cnt_d    = top_g + CW'(1);
			end else begin
				st_d  = scba_pkg::ST_EXHAUSTED;
				cnt_d = count_q[first_cls];
			end
		end else begin
			if (32'(req.free_class) >= 32'(NUM_CLASSES)) begin
				st_d = scba_pkg::ST_FREE_ERR;
			end else if (32'(req.free_block) >= 32'(BLOCKS_PER_CLASS)
					|| count_q[fcls_idx] == '0) begin
				st_d  = scba_pkg::ST_FREE_ERR;
				cnt_d = count_q[fcls_idx];
			end else begin
				do_free = 1'b1;
				st_d    = scba_pkg::ST_FREED;
				cnt_d   = top_f;
			end
		end
	end

	// Stack addresses: class base plus stack position
	assign raddr = AW'(grant_cls) * AW'(BLOCKS_PER_CLASS) + AW'(top_g);
	assign waddr = AW'(fcls_idx) * AW'(BLOCKS_PER_CLASS) + AW'(top_f);

	scba_ram #(
		.WIDTH(BW),
		.DEPTH(NUM_CLASSES * BLOCKS_PER_CLASS)
	) u_stack (
		.clk  (clk),
		.we   (in_acc && do_free),
		.waddr(waddr),
		.wdata(BW'(req.free_block)),
		.re   (in_acc && do_grant),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Update in-use counts and peak marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				count_q[c] <= '0;
				peak_q[c]  <= '0;
			end
		end else if (in_acc) begin
			if (do_grant) begin
				count_q[grant_cls] <= top_g + CW'(1);
				if (!use_mem) begin
					peak_q[grant_cls] <= top_g + CW'(1);
				end
			end else if (do_free) begin
				count_q[fcls_idx] <= top_f;
			end
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1  <= st_d;
			cls_s1 <= cls_d;
			cnt_s1 <= cnt_d;
			mem_s1 <= do_grant && use_mem;
			rst_s1 <= do_grant ? BW'(top_g) : '0;
		end
	end

	// Response register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response register payload: pick stack word or untouched slot index
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.status       <= st_s1;
			rsp_q.grant_class  <= cls_s1;
			rsp_q.grant_block  <= 8'(mem_s1 ? rdata : rst_s1);
			rsp_q.class_in_use <= 9'(cnt_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/scba_ram.sv
module scba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; hold the last word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/scba_checker.sv
module scba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input scba_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input scba_pkg::rsp_t rsp
);

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

	// Only a grant carries a class and block
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != scba_pkg::ST_GRANTED
		|-> rsp.grant_class == '0 && rsp.grant_block == '0)
		else $error("class or block reported without a grant");

	// Zero-size and too-large requests report no count
	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == scba_pkg::ST_ZERO
			|| rsp.status == scba_pkg::ST_TOO_LARGE)
		|-> rsp.class_in_use == '0)
		else $error("rejected size reports a count");

	// A grant leaves at least one block in use
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == scba_pkg::ST_GRANTED |-> rsp.class_in_use != '0)
		else $error("grant with zero blocks in use");

	// Hold a stalled request beat
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request beat changed");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
